@@ sv/dps_pkg.sv @@
// package: shared types and constants for the dense prim spanning tree block
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;
	localparam int KEY_BITS = 17;
	localparam logic [KEY_BITS-1:0] KEY_INIT = 17'd99999;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_PICK = 4'b0010,
		ST_RELAX = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// control broadcast from the sequencer to the cell chain
	typedef struct packed {
		logic clear;
		logic scan;
		logic relax;
		logic emit_shift;
	} cell_ctrl_t;
endpackage
`default_nettype wire

@@ sv/dps_cell.sv @@
// one vertex cell: key, tree flag and parent, with a shift path to its neighbor
`timescale 1ns / 1ps
`default_nettype none
module dps_cell #(
	parameter int IDX_BITS = 6,
	parameter int WEIGHT_BITS = 16,
	parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
	input wire clk,
	input wire arst_n,
	input wire dps_pkg::cell_ctrl_t ctrl,
	input wire active,
	input wire [IDX_BITS-1:0] pick_idx,
	input wire [IDX_BITS-1:0] relax_idx,
	input wire [WEIGHT_BITS-1:0] relax_wt,
	input wire [dps_pkg::KEY_BITS-1:0] key_in,
	input wire [IDX_BITS-1:0] par_in,
	input wire has_in,
	input wire tree_in,
	output logic [dps_pkg::KEY_BITS-1:0] key_q,
	output logic [IDX_BITS-1:0] par_q,
	output logic has_q,
	output logic tree_q
);
	import dps_pkg::*;
	logic [KEY_BITS-1:0] wt_ext;
	assign wt_ext = KEY_BITS'(relax_wt);

	// state update: clear, mark picked, relax through weight, or shift out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= (MY_IDX == '0) ? '0 : KEY_INIT;
			tree_q <= 1'b0;
			has_q <= 1'b0;
			par_q <= '0;
		end else if (ctrl.clear) begin
			key_q <= (MY_IDX == '0) ? '0 : KEY_INIT;
			tree_q <= 1'b0;
			has_q <= 1'b0;
		end else if (ctrl.emit_shift) begin
			key_q <= key_in;
			par_q <= par_in;
			has_q <= has_in;
			tree_q <= tree_in;
		end else if (ctrl.scan) begin
			if (active && pick_idx == MY_IDX) tree_q <= 1'b1;
		end else if (ctrl.relax) begin
			if (active && relax_idx == MY_IDX && relax_wt != '0 && !tree_q
			    && wt_ext < key_q) begin
				key_q <= wt_ext;
				par_q <= pick_idx;
				has_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/dps_min_chain.sv @@
// running minimum over the vertices stepped in, one vertex a cycle while step is high
`timescale 1ns / 1ps
`default_nettype none
module dps_min_chain #(
	parameter int IDX_BITS = 6
) (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire step,
	input wire [IDX_BITS-1:0] idx,
	input wire [dps_pkg::KEY_BITS-1:0] key,
	input wire in_tree,
	output logic [IDX_BITS-1:0] best_idx_q,
	output logic [dps_pkg::KEY_BITS-1:0] best_key_q,
	output logic found_q
);
	import dps_pkg::*;
	// strict less keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_idx_q <= '0;
			best_key_q <= '0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (step && !in_tree && (!found_q || key < best_key_q)) begin
			found_q <= 1'b1;
			best_idx_q <= idx;
			best_key_q <= key;
		end
	end
endmodule
`default_nettype wire

@@ sv/dense_prim_spanning_tree.sv @@
// top level: matrix store, sequencer and vertex cell chain
`timescale 1ns / 1ps
`default_nettype none
// Dense Prim minimum spanning tree.
// in channel (valid/ready, weight): n*n weights of the adjacency matrix in
// row-major order, n = vertex_count clamped to 2..MAX_VERTICES; 0 = no edge.
// out channel (valid/ready): n result words, one per vertex in index order,
// with parent, edge_weight, no_parent and last on vertex n-1.
// Load stores each accepted weight at the next address. After the last weight,
// n-1 rounds run, each a scan over the cells and a relax pass reading one
// matrix word a cycle; the run time is set by the one-cell-a-cycle scan and
// the single read port of the matrix memory.
// Results then shift out of the cell chain,
// one per accepted word; a stall on out ready holds the chain.
// in ready is low from the last weight until the last result is taken.
// Reset clears keys, tree flags and counts at once; the matrix memory is
// not cleared since every entry is written before it is read.
// A vertex_count write restarts the load count.
module dense_prim_spanning_tree #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [6:0] cfg_wdata,
	input wire in_valid,
	output logic in_ready,
	input wire [15:0] weight,
	output logic out_valid,
	input wire out_ready,
	output logic [5:0] vertex,
	output logic [5:0] parent,
	output logic [16:0] edge_weight,
	output logic no_parent,
	output logic last
);
	import dps_pkg::*;
	localparam int IB = $clog2(MAX_VERTICES);
	localparam int AB = 2 * IB;
	localparam int CB = IB + 1;

	state_t state_q;
	logic [6:0] vcount_q;
	logic [CB-1:0] n;
	logic [AB:0] load_q;
	logic [AB:0] total;
	logic [CB-1:0] cnt_q, round_q;
	logic [IB-1:0] pick_q;
	logic [WEIGHT_BITS-1:0] mem [MAX_VERTICES*MAX_VERTICES];
	logic [WEIGHT_BITS-1:0] rd_q;
	logic [IB-1:0] rdidx_s1;
	logic rdv_s1;
	logic [AB-1:0] base_q;
	cell_ctrl_t ctrl;

	// clamp of the side length
	always_comb begin
		if (vcount_q < 7'd2) n = CB'(2);
		else if (vcount_q > 7'(MAX_VERTICES)) n = CB'(MAX_VERTICES);
		else n = CB'(vcount_q);
	end
	assign total = (AB+1)'(n) * (AB+1)'(n);

	logic [KEY_BITS-1:0] keys [MAX_VERTICES];
	logic [IB-1:0] pars [MAX_VERTICES];
	logic hass [MAX_VERTICES];
	logic trees [MAX_VERTICES];

	logic in_acc, out_acc;
	assign in_acc = in_valid && in_ready;
	assign in_ready = (state_q == ST_LOAD);
	assign out_acc = out_valid && out_ready;

	// scan reads cell cnt_q through a mux (one reader, fixed cells)
	logic [IB-1:0] scan_idx;
	assign scan_idx = cnt_q[IB-1:0];
	logic [IB-1:0] mbest;
	logic [KEY_BITS-1:0] mkey;
	logic mfound;
	dps_min_chain #(.IDX_BITS(IB)) u_min (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == ST_RELAX), .step(state_q == ST_PICK && cnt_q < n),
		.idx(scan_idx), .key(keys[scan_idx]), .in_tree(trees[scan_idx]),
		.best_idx_q(mbest), .best_key_q(mkey), .found_q(mfound)
	);

	// matrix memory, up to one write and one read a cycle
	always_ff @(posedge clk) begin
		if (in_acc) mem[load_q[AB-1:0]] <= weight[WEIGHT_BITS-1:0];
		rd_q <= mem[base_q + AB'(cnt_q[IB-1:0])];
	end

	logic done_scan, stop;
	assign done_scan = (state_q == ST_PICK) && (cnt_q == n);
	assign stop = done_scan && !mfound;

	always_comb begin
		ctrl.clear = 1'b0;
		ctrl.scan = done_scan && mfound;
		ctrl.relax = (state_q == ST_RELAX) && rdv_s1;
		ctrl.emit_shift = out_acc;
		if (out_acc && last) ctrl.clear = 1'b1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vcount_q <= 7'd64;
			load_q <= '0;
			cnt_q <= '0;
			round_q <= '0;
			pick_q <= '0;
			base_q <= '0;
			rdv_s1 <= 1'b0;
			rdidx_s1 <= '0;
		end else begin
			rdv_s1 <= 1'b0;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
				load_q <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_q + 1'b1 >= total) begin
							load_q <= '0;
							state_q <= ST_PICK;
							cnt_q <= '0;
							round_q <= CB'(1);
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
				end
				ST_PICK: begin
					if (cnt_q == n) begin
						cnt_q <= '0;
						if (!mfound) begin
							state_q <= ST_EMIT;
						end else begin
							pick_q <= mbest;
							base_q <= AB'((AB+1)'(mbest) * (AB+1)'(n));
							state_q <= ST_RELAX;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RELAX: begin
					if (cnt_q < n) begin
						rdv_s1 <= 1'b1;
						rdidx_s1 <= cnt_q[IB-1:0];
						cnt_q <= cnt_q + 1'b1;
					end else if (!rdv_s1) begin
						cnt_q <= '0;
						if (round_q + 1'b1 == n) state_q <= ST_EMIT;
						else begin
							round_q <= round_q + 1'b1;
							state_q <= ST_PICK;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						cnt_q <= cnt_q + 1'b1;
						if (last) begin
							state_q <= ST_LOAD;
							cnt_q <= '0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// vertex cell chain; emit shifts toward cell 0
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		logic [KEY_BITS-1:0] kn;
		logic [IB-1:0] pn;
		logic hn, tn;
		if (i == MAX_VERTICES - 1) begin : g_end
			assign kn = KEY_INIT;
			assign pn = '0;
			assign hn = 1'b0;
			assign tn = 1'b0;
		end else begin : g_mid
			assign kn = keys[i+1];
			assign pn = pars[i+1];
			assign hn = hass[i+1];
			assign tn = trees[i+1];
		end
		dps_cell #(.IDX_BITS(IB), .WEIGHT_BITS(WEIGHT_BITS), .MY_IDX(IB'(i))) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.active(CB'(i) < n),
			.pick_idx(ctrl.scan ? mbest : pick_q),
			.relax_idx(rdidx_s1), .relax_wt(rd_q),
			.key_in(kn), .par_in(pn), .has_in(hn), .tree_in(tn),
			.key_q(keys[i]), .par_q(pars[i]), .has_q(hass[i]), .tree_q(trees[i])
		);
	end

	// output word from the head cell
	assign out_valid = (state_q == ST_EMIT);
	assign vertex = 6'(cnt_q[IB-1:0]);
	assign parent = hass[0] ? 6'(pars[0]) : 6'd0;
	assign edge_weight = keys[0];
	assign no_parent = !hass[0];
	assign last = (cnt_q + 1'b1 == n);

	// checks
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while emitting");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex))
		else $error("result dropped under stall");
	a_last_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last |=> state_q == ST_LOAD) else $error("no return to load");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stop |=> state_q == ST_EMIT) else $error("stop missed");
endmodule
`default_nettype wire

@@ tb/sv/dense_prim_spanning_tree_test.sv @@
// testbench: random and directed matrix loads checked against a prim predictor
`timescale 1ns / 1ps
module dense_prim_spanning_tree_test;
	import dps_pkg::*;

	localparam int MAXV = 64;
	localparam int IDLE_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [5:0] vertex;
		logic [5:0] parent;
		logic [16:0] edge_weight;
		logic no_parent;
		logic last;
	} tree_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [15:0] weight = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [5:0] vertex;
	logic [5:0] parent;
	logic [16:0] edge_weight;
	logic no_parent;
	logic last;

	// predictor state
	logic [15:0] matrix [0:MAXV*MAXV-1];
	int side = MAXV;
	int loaded = 0;
	tree_word_t tree_q [$];

	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;

	dense_prim_spanning_tree uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .weight(weight),
		.out_valid(out_valid), .out_ready(out_ready), .vertex(vertex),
		.parent(parent), .edge_weight(edge_weight), .no_parent(no_parent),
		.last(last)
	);

	always #1 clk = ~clk;

	// grow the tree once the matrix is complete and queue one word per vertex
	task automatic grow_tree();
		logic [16:0] key [0:MAXV-1];
		bit done [0:MAXV-1];
		bit linked [0:MAXV-1];
		logic [5:0] up [0:MAXV-1];
		int pick;
		int best;
		tree_word_t tw;
		for (int v = 0; v < MAXV; v++) begin
			key[v] = KEY_INIT;
			done[v] = 0;
			linked[v] = 0;
			up[v] = 0;
		end
		key[0] = 0;
		for (int r = 0; r + 1 < side; r++) begin
			pick = -1;
			best = 0;
			for (int v = 0; v < side; v++) begin
				if (!done[v] && (pick < 0 || key[v] < best)) begin
					best = key[v];
					pick = v;
				end
			end
			if (pick < 0)
				break;
			done[pick] = 1;
			for (int w = 0; w < side; w++) begin
				logic [15:0] wt;
				wt = matrix[pick*side + w];
				if (wt != 0 && !done[w] && wt < key[w]) begin
					key[w] = wt;
					up[w] = pick[5:0];
					linked[w] = 1;
				end
			end
		end
		for (int v = 0; v < side; v++) begin
			tw.vertex = v[5:0];
			tw.parent = linked[v] ? up[v] : 6'd0;
			tw.edge_weight = key[v];
			tw.no_parent = !linked[v];
			tw.last = (v + 1 == side);
			tree_q = {tree_q, tw};
		end
	endtask

	task automatic store_weight(input logic [15:0] w);
		matrix[loaded] = w;
		loaded++;
		if (loaded == side*side) begin
			grow_tree();
			loaded = 0;
		end
	endtask

	// offer one word and wait for it to be taken
	task automatic send_word(input logic [15:0] w);
		if (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		weight <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		store_weight(w);
	endtask

	task automatic stop_sending();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (tree_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, block idle and input channel quiet
	task automatic set_vertex_count(input logic [6:0] val);
		cfg_we <= 1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		side = (val < 2) ? 2 : (val > MAXV) ? MAXV : val;
		loaded = 0;
	endtask

	function automatic logic [15:0] rand_weight();
		int sel;
		sel = $urandom_range(99);
		if (sel < 30)
			return 16'd0;
		if (sel < 60)
			return 16'($urandom_range(1, 6));
		return 16'($urandom());
	endfunction

	task automatic send_random_matrix();
		for (int i = 0; i < side*side; i++)
			send_word(rand_weight());
	endtask

	// side clamped up to 2, extremes of the weight field
	task automatic test_smallest();
		set_vertex_count(7'd0);
		send_word(16'd0);
		send_word(16'hffff);
		send_word(16'hffff);
		send_word(16'd0);
		stop_sending();
		wait_drained();
		set_vertex_count(7'd1);
		send_word(16'd0);
		send_word(16'd0);
		send_word(16'd0);
		send_word(16'd0);
		stop_sending();
		wait_drained();
	endtask

	// ties, an isolated vertex and an asymmetric edge
	task automatic test_ties_isolated();
		logic [15:0] m [0:15] = '{
			16'd0, 16'd5, 16'd5, 16'd0,
			16'd5, 16'd0, 16'd1, 16'd0,
			16'd5, 16'd1, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd7, 16'd0};
		set_vertex_count(7'd4);
		foreach (m[i])
			send_word(m[i]);
		stop_sending();
		wait_drained();
	endtask

	// vertex_count write in the middle of a load drops the partial matrix
	task automatic test_abort_load();
		set_vertex_count(7'd3);
		repeat (5) send_word(rand_weight());
		stop_sending();
		repeat (SETTLE_CYCLES) @(posedge clk);
		set_vertex_count(7'd3);
		send_random_matrix();
		stop_sending();
		wait_drained();
	endtask

	// side clamped down to 64: a short partial load must not finish a matrix
	task automatic test_clamp_high();
		set_vertex_count(7'd127);
		repeat (10) send_word(rand_weight());
		stop_sending();
		repeat (SETTLE_CYCLES) @(posedge clk);
		set_vertex_count(7'd5);
		send_random_matrix();
		stop_sending();
		wait_drained();
	endtask

	// receiver holds off while matrices keep coming
	task automatic test_backpressure();
		set_vertex_count(7'd2);
		hold_req = 1;
		repeat (3) send_random_matrix();
		stop_sending();
		wait_drained();
	endtask

	// random small sides, a quiet stretch and a full pause in between
	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 30) begin
			set_vertex_count(7'($urandom_range(2, 6)));
			quiet = (sent >= 10 && sent < 30);
			send_random_matrix();
			sent += side*side;
			stop_sending();
			wait_drained();
		end
		quiet = 0;
		set_vertex_count(7'($urandom_range(2, 4)));
		send_random_matrix();
		stop_sending();
		wait_drained();
	endtask

	// receiver side: random stalls, a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
		end
	end

	// compare each taken word with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tree_q.size() == 0) begin
				$error("unexpected word for vertex %0d", vertex);
				errors++;
			end else begin
				tree_word_t e;
				e = tree_q.pop_front();
				if (vertex !== e.vertex) begin
					$error("vertex: expected %0d, got %0d", e.vertex, vertex);
					errors++;
				end
				if (parent !== e.parent) begin
					$error("parent: expected %0d, got %0d", e.parent, parent);
					errors++;
				end
				if (edge_weight !== e.edge_weight) begin
					$error("edge_weight: expected %0d, got %0d", e.edge_weight, edge_weight);
					errors++;
				end
				if (no_parent !== e.no_parent) begin
					$error("no_parent: expected %0d, got %0d", e.no_parent, no_parent);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("dense_prim_spanning_tree_test: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_smallest();
		test_ties_isolated();
		test_abort_load();
		test_backpressure();
		test_random();
		test_clamp_high();
		if (errors == 0 && tree_q.size() == 0)
			$display("dense_prim_spanning_tree_test: PASS");
		else
			$display("dense_prim_spanning_tree_test: FAIL");
		$finish;
	end
endmodule

@@ files.f @@
sv/dps_pkg.sv
sv/dps_cell.sv
sv/dps_min_chain.sv
sv/dense_prim_spanning_tree.sv
tb/sv/dense_prim_spanning_tree_test.sv
